// File: hw/rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Types and constants shared by the first-fit chunk allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ffca_pkg;
	localparam int FUNC_W = 2;
	localparam int REQ_W  = 13;
	localparam int OFF_W  = 12;
	localparam int ST_W   = 2;
	localparam int LF_W   = 13;
	localparam int CFG_W  = 13;
	localparam logic [CFG_W-1:0] USABLE_RST = 13'd4096;

	typedef enum logic [FUNC_W-1:0] {
		FN_INIT  = 2'd0,
		FN_ALLOC = 2'd1,
		FN_FREE  = 2'd2,
		FN_QUERY = 2'd3
	} func_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_P    = 2'd1,
		RD_E    = 2'd2
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE  = 3'd0,
		WR_INIT  = 3'd1,
		WR_NEG   = 3'd2,
		WR_MERGE = 3'd3,
		WR_SPLIT = 3'd4,
		WR_ALLOC = 3'd5
	} wr_sel_t;

	typedef struct packed {
		logic    start;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    load_cur;
		logic    merge;
		logic    advance;
		logic    best_upd;
		logic    set_st;
		status_t st;
		logic    set_gr;
		logic    init;
		logic    load_out;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  ready;
		logic  req_zero;
		logic  off_lt_h;
		logic  cond;
		logic  e_lt_end;
		logic  p_lt_h;
		logic  p_eq_h;
		logic  cur_pos;
		logic  cur_neg;
		logic  nxt_pos;
		logic  fit_whole;
		logic  fit_split;
	} dp_stat_t;
endpackage
`default_nettype wire

// File: hw/rtl/ffca_if.sv
// ----------------------------------------------------------------------------
// ffca_if
// Request and result channels of the first-fit chunk allocator.
// ----------------------------------------------------------------------------
`default_nettype none
interface ffca_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [12:0] req_bytes;
	logic [11:0] payload_offset;
	modport source (output valid, func, req_bytes, payload_offset, input ready);
	modport sink (input valid, func, req_bytes, payload_offset, output ready);
endinterface

interface ffca_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] granted_offset;
	logic [12:0] largest_free;
	modport source (output valid, status, granted_offset, largest_free, input ready);
	modport sink (input valid, status, granted_offset, largest_free, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/first_fit_chunk_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator_unit
// First-fit allocator over a segment kept as an implicit list of chunk headers.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch (func, req_bytes, payload_offset) and each one
// produces exactly one transfer on rsp_ch (status, granted_offset,
// largest_free). The APB port holds usable_bytes at address 0; it is sampled
// by an init request.
// Init passes through the dispatch and done states to the output register.
// Allocate, free and query walk the chunk list through a single-port header
// store, one header visited or merged at a time. One request is processed at
// a time.
// A finished result sits in an output register, so the next request is
// accepted while it waits; a stalled receiver holds the walk at its end.
// Reset clears the list, so every request before the first init behaves as
// on an empty allocator; the header store itself needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_chunk_allocator_unit #(
	parameter int SEGMENT_BYTES = 4096,
	parameter int HEADER_BYTES  = 8,
	parameter int ALIGN_BYTES   = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ffca_req_if.sink    req_ch,
	ffca_rsp_if.source  rsp_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import ffca_pkg::*;

	logic [CFG_W-1:0] usable_q;
	dp_cmd_t          cmd;
	dp_stat_t         stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= USABLE_RST;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			usable_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr == 3'd0) ? 32'(usable_q) : '0;

	ffca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_ch.valid),
		.in_ready  (req_ch.ready),
		.out_valid (rsp_ch.valid),
		.out_ready (rsp_ch.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ffca_datapath #(
		.SEGMENT_BYTES (SEGMENT_BYTES),
		.HEADER_BYTES  (HEADER_BYTES),
		.ALIGN_BYTES   (ALIGN_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.func           (req_ch.func),
		.req_bytes      (req_ch.req_bytes),
		.payload_offset (req_ch.payload_offset),
		.usable_bytes   (usable_q),
		.status         (rsp_ch.status),
		.granted_offset (rsp_ch.granted_offset),
		.largest_free   (rsp_ch.largest_free)
	);
endmodule
`default_nettype wire

// File: hw/rtl/ffca_datapath.sv
// ----------------------------------------------------------------------------
// ffca_datapath
// Header store, walk pointer, current header and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module ffca_datapath #(
	parameter int SEGMENT_BYTES = 4096,
	parameter int HEADER_BYTES  = 8,
	parameter int ALIGN_BYTES   = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ffca_pkg::dp_cmd_t           cmd,
	output ffca_pkg::dp_stat_t               stat,
	input  wire logic [ffca_pkg::FUNC_W-1:0] func,
	input  wire logic [ffca_pkg::REQ_W-1:0]  req_bytes,
	input  wire logic [ffca_pkg::OFF_W-1:0]  payload_offset,
	input  wire logic [ffca_pkg::CFG_W-1:0]  usable_bytes,
	output logic [ffca_pkg::ST_W-1:0]        status,
	output logic [ffca_pkg::OFF_W-1:0]       granted_offset,
	output logic [ffca_pkg::LF_W-1:0]        largest_free
);
	import ffca_pkg::*;

	localparam int PW    = $clog2(SEGMENT_BYTES) + 1;
	localparam int SW    = PW + 1;
	localparam int VW    = ((PW > REQ_W + 1) ? PW : REQ_W + 1) + 2;
	localparam int GRAN  = (HEADER_BYTES < ALIGN_BYTES) ? HEADER_BYTES : ALIGN_BYTES;
	localparam int GS    = $clog2(GRAN);
	localparam int DEPTH = SEGMENT_BYTES / GRAN;
	localparam int AW    = $clog2(DEPTH);
	localparam logic signed [VW-1:0] HDR = VW'(HEADER_BYTES);
	localparam logic signed [VW-1:0] ALN = VW'(ALIGN_BYTES);
	localparam logic signed [VW-1:0] SEG = VW'(SEGMENT_BYTES);

	logic signed [SW-1:0] mem [DEPTH];
	logic signed [SW-1:0] rdata_q;

	func_t                func_q;
	logic signed [VW-1:0] cs_q, h_q, p_q, cur_q, best_q, end_q;
	logic                 ready_q, req_zero_q, off_lt_h_q;
	status_t              st_q;
	logic [OFF_W-1:0]     gr_q;
	logic [ST_W-1:0]      out_st_q;
	logic [OFF_W-1:0]     out_gr_q;
	logic [LF_W-1:0]      out_lf_q;

	logic signed [VW-1:0] req_x, cs_d, mag, e, nxt, merged, usable_x, u_c, u_r, u_f;
	logic signed [VW-1:0] waddr_b, raddr_b, wdata;
	logic                 wr_en;

	always_comb begin
		req_x    = VW'(req_bytes);
		cs_d     = (req_x + ALN - VW'(1)) & ~(ALN - VW'(1));
		mag      = cur_q[VW-1] ? -cur_q : cur_q;
		e        = p_q + HDR + mag;
		nxt      = VW'(rdata_q);
		merged   = cur_q + nxt + HDR;
		usable_x = VW'(usable_bytes);
		u_c      = (usable_x > SEG) ? SEG : usable_x;
		u_r      = u_c & ~(ALN - VW'(1));
		u_f      = (u_r < HDR + ALN) ? HDR + ALN : u_r;
	end

	always_comb begin
		wr_en   = 1'b1;
		waddr_b = p_q;
		wdata   = '0;
		case (cmd.wr_sel)
			WR_INIT: begin
				waddr_b = '0;
				wdata   = u_f - HDR;
			end
			WR_NEG: wdata = -cur_q;
			WR_MERGE: wdata = merged;
			WR_SPLIT: begin
				waddr_b = p_q + HDR + cs_q;
				wdata   = cur_q - cs_q - HDR;
			end
			WR_ALLOC: wdata = -cs_q;
			default: wr_en = 1'b0;
		endcase
		raddr_b = (cmd.rd_sel == RD_E) ? e : p_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr_b[AW+GS-1:GS]] <= wdata[SW-1:0];
		end
		if (cmd.rd_sel != RD_NONE) begin
			rdata_q <= mem[raddr_b[AW+GS-1:GS]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			end_q   <= '0;
		end else if (cmd.init) begin
			ready_q <= 1'b1;
			end_q   <= u_f;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q     <= func_t'(func);
			cs_q       <= cs_d;
			h_q        <= VW'(payload_offset) - HDR;
			req_zero_q <= (req_bytes == '0);
			off_lt_h_q <= (VW'(payload_offset) < HDR);
			p_q        <= '0;
			best_q     <= '0;
			st_q       <= ST_OK;
			gr_q       <= '0;
		end else begin
			if (cmd.load_cur) begin
				cur_q <= nxt;
			end
			if (cmd.merge) begin
				cur_q <= merged;
			end
			if (cmd.best_upd && cur_q > best_q) begin
				best_q <= cur_q;
			end
			if (cmd.advance) begin
				p_q   <= e;
				cur_q <= nxt;
			end
			if (cmd.set_st) begin
				st_q <= cmd.st;
			end
			if (cmd.set_gr) begin
				gr_q <= OFF_W'(p_q + HDR);
			end
		end
		if (cmd.load_out) begin
			out_st_q <= st_q;
			out_gr_q <= gr_q;
			out_lf_q <= (func_q == FN_QUERY) ? LF_W'(best_q) : '0;
		end
	end

	always_comb begin
		stat.func      = func_q;
		stat.ready     = ready_q;
		stat.req_zero  = req_zero_q;
		stat.off_lt_h  = off_lt_h_q;
		stat.e_lt_end  = e < end_q;
		stat.cond      = (e < end_q) && (cs_q > cur_q);
		stat.p_lt_h    = p_q < h_q;
		stat.p_eq_h    = p_q == h_q;
		stat.cur_pos   = cur_q > 0;
		stat.cur_neg   = cur_q < 0;
		stat.nxt_pos   = nxt > 0;
		stat.fit_whole = (cs_q <= cur_q) && (cs_q + HDR >= cur_q);
		stat.fit_split = (cs_q + HDR) < cur_q;
	end

	assign status         = out_st_q;
	assign granted_offset = out_gr_q;
	assign largest_free   = out_lf_q;
endmodule
`default_nettype wire

// File: hw/rtl/ffca_ctrl.sv
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer for init, allocate, free and query walks over the chunk list.
// ----------------------------------------------------------------------------
`default_nettype none
module ffca_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output ffca_pkg::dp_cmd_t       cmd,
	input  wire ffca_pkg::dp_stat_t stat
);
	import ffca_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b0_0000_0001,
		S_DISP = 9'b0_0000_0010,
		S_LD   = 9'b0_0000_0100,
		S_EVAL = 9'b0_0000_1000,
		S_NXT  = 9'b0_0001_0000,
		S_SPL  = 9'b0_0010_0000,
		S_DONE = 9'b0_0100_0000,
		S_SPR  = 9'b0_1000_0000,
		S_MRG  = 9'b1_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.start = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				case (stat.func)
					FN_INIT: begin
						cmd.wr_sel = WR_INIT;
						cmd.init   = 1'b1;
					end
					FN_ALLOC: begin
						if (stat.req_zero) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_BAD;
						end else if (!stat.ready) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_NOFIT;
						end else begin
							cmd.rd_sel = RD_P;
							state_d    = S_LD;
						end
					end
					FN_FREE: begin
						if (stat.ready && !stat.off_lt_h) begin
							cmd.rd_sel = RD_P;
							state_d    = S_LD;
						end
					end
					default: begin
						if (stat.ready) begin
							cmd.rd_sel = RD_P;
							state_d    = S_LD;
						end
					end
				endcase
			end
			S_LD: begin
				cmd.load_cur = 1'b1;
				state_d      = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_DONE;
				case (stat.func)
					FN_ALLOC: begin
						if (stat.cond) begin
							cmd.rd_sel = RD_E;
							state_d    = S_NXT;
						end else if (stat.fit_whole) begin
							cmd.wr_sel = WR_NEG;
							cmd.set_gr = 1'b1;
						end else if (stat.fit_split) begin
							cmd.wr_sel = WR_SPLIT;
							state_d    = S_SPL;
						end else begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_NOFIT;
						end
					end
					FN_FREE: begin
						if (stat.p_lt_h) begin
							if (stat.e_lt_end) begin
								cmd.rd_sel = RD_E;
								state_d    = S_NXT;
							end
						end else if (stat.p_eq_h && stat.cur_neg) begin
							cmd.wr_sel = WR_NEG;
						end
					end
					FN_QUERY: begin
						if (stat.e_lt_end) begin
							cmd.rd_sel = RD_E;
							state_d    = S_NXT;
						end else begin
							cmd.best_upd = 1'b1;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_NXT: begin
				state_d = S_EVAL;
				if (stat.func != FN_FREE && stat.cur_pos && stat.nxt_pos) begin
					cmd.merge  = 1'b1;
					cmd.wr_sel = WR_MERGE;
					if (stat.func == FN_ALLOC) begin
						state_d = S_MRG;
					end
				end else if (stat.func == FN_ALLOC && !stat.cond) begin
					state_d = S_EVAL;
				end else begin
					cmd.best_upd = 1'b1;
					cmd.advance  = 1'b1;
				end
			end
			S_MRG: begin
				if (stat.e_lt_end) begin
					cmd.rd_sel = RD_E;
					state_d    = S_NXT;
				end else begin
					state_d = S_EVAL;
				end
			end
			S_SPL: begin
				cmd.wr_sel = WR_ALLOC;
				cmd.set_gr = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_DISP)
		else $error("accepted request did not start a walk");
	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && out_valid_q |-> out_ready)
		else $error("result overwritten before its transfer");
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_sel != RD_NONE |-> cmd.wr_sel == WR_NONE)
		else $error("header store read and write in one cycle");
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit chunk allocator. A directed table and
// a random mix of init, allocate, free and query requests are sent under
// several usable sizes, each response is checked against its table row or a
// software model of the chunk list; both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
	import ffca_pkg::*;

	typedef struct {
		status_t     st;
		logic [11:0] gr;
		logic [12:0] lf;
	} rsp_t;

	typedef struct {
		func_t fn;
		int    req;
		int    off;
		bit    typed;
		status_t st;
		int    gr;
		int    lf;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ffca_req_if req_ch ();
	ffca_rsp_if rsp_ch ();

	first_fit_chunk_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch.sink),
		.rsp_ch(rsp_ch.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	int   headers [0:4095];
	int   list_end;
	bit   list_ready;
	int   usable_reg;
	rsp_t pending_rsp[$];
	int   live_offsets[$];
	int   errors;
	int   mismatches;
	bit   hold_req;

	row_t dir_rows [25] = '{
		'{FN_ALLOC, 8, 0, 1, ST_NOFIT, 0, 0},
		'{FN_QUERY, 0, 0, 1, ST_OK, 0, 0},
		'{FN_FREE, 0, 8, 1, ST_OK, 0, 0},
		'{FN_ALLOC, 0, 0, 1, ST_BAD, 0, 0},
		'{FN_INIT, 0, 0, 1, ST_OK, 0, 0},
		'{FN_QUERY, 0, 0, 1, ST_OK, 0, 4088},
		'{FN_ALLOC, 1, 0, 1, ST_OK, 8, 0},
		'{FN_ALLOC, 8191, 0, 1, ST_NOFIT, 0, 0},
		'{FN_ALLOC, 0, 0, 1, ST_BAD, 0, 0},
		'{FN_FREE, 0, 4095, 1, ST_OK, 0, 0},
		'{FN_FREE, 0, 0, 1, ST_OK, 0, 0},
		'{FN_FREE, 0, 8, 1, ST_OK, 0, 0},
		'{FN_ALLOC, 4080, 0, 1, ST_OK, 8, 0},
		'{FN_QUERY, 0, 0, 1, ST_OK, 0, 0},
		'{FN_FREE, 0, 8, 1, ST_OK, 0, 0},
		'{FN_ALLOC, 4088, 0, 1, ST_OK, 8, 0},
		'{FN_FREE, 0, 8, 1, ST_OK, 0, 0},
		'{FN_ALLOC, 16, 0, 1, ST_OK, 8, 0},
		'{FN_ALLOC, 24, 0, 0, ST_OK, 0, 0},
		'{FN_ALLOC, 9, 0, 0, ST_OK, 0, 0},
		'{FN_FREE, 0, 32, 0, ST_OK, 0, 0},
		'{FN_FREE, 0, 8, 0, ST_OK, 0, 0},
		'{FN_QUERY, 0, 0, 0, ST_OK, 0, 0},
		'{FN_ALLOC, 4096, 0, 0, ST_OK, 0, 0},
		'{FN_ALLOC, 8, 0, 0, ST_OK, 0, 0}
	};

	always #6 clk = ~clk;

	initial begin
		#200ms;
		$display("tb_top: errors");
		$finish;
	end

	function automatic int chunk_next(int p);
		return p + 8 + (headers[p] < 0 ? -headers[p] : headers[p]);
	endfunction

	function automatic void coalesce(int p);
		int n;
		if (headers[p] <= 0)
			return;
		while (chunk_next(p) < list_end) begin
			n = chunk_next(p);
			if (headers[n] <= 0)
				break;
			headers[p] += headers[n] + 8;
		end
	endfunction

	function automatic rsp_t allocator_step(func_t fn, int req, int off);
		rsp_t r;
		int u, cs, p, s, h, best;
		r.st = ST_OK;
		r.gr = '0;
		r.lf = '0;
		p = 0;
		case (fn)
			FN_INIT: begin
				u = usable_reg > 4096 ? 4096 : usable_reg;
				u -= u % 8;
				if (u < 16)
					u = 16;
				list_end = u;
				headers[0] = u - 8;
				list_ready = 1;
			end
			FN_ALLOC: begin
				if (req == 0) begin
					r.st = ST_BAD;
				end else if (!list_ready) begin
					r.st = ST_NOFIT;
				end else begin
					cs = req + (8 - req % 8) % 8;
					while (chunk_next(p) < list_end && cs > headers[p]) begin
						coalesce(p);
						if (chunk_next(p) < list_end && cs > headers[p])
							p = chunk_next(p);
					end
					s = headers[p];
					if (cs <= s && cs + 8 >= s) begin
						headers[p] = -s;
						r.gr = 12'(p + 8);
					end else if (cs + 8 < s) begin
						headers[p + 8 + cs] = s - cs - 8;
						headers[p] = -cs;
						r.gr = 12'(p + 8);
					end else begin
						r.st = ST_NOFIT;
					end
				end
			end
			FN_FREE: begin
				if (list_ready && off >= 8) begin
					h = off - 8;
					while (p < h && p < list_end)
						p = chunk_next(p);
					if (p == h && p < list_end && headers[p] < 0)
						headers[p] = -headers[p];
				end
			end
			default: begin
				best = 0;
				if (list_ready) begin
					forever begin
						coalesce(p);
						if (headers[p] > best)
							best = headers[p];
						if (chunk_next(p) >= list_end)
							break;
						p = chunk_next(p);
					end
				end
				r.lf = 13'(best);
			end
		endcase
		return r;
	endfunction

	task automatic send_request(func_t fn, int req, int off, bit typed, rsp_t typed_rsp);
		rsp_t r;
		int i;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.req_bytes <= req[12:0];
		req_ch.payload_offset <= off[11:0];
		do
			@(posedge clk);
		while (!req_ch.ready);
		r = allocator_step(fn, req, off);
		if (typed)
			r = typed_rsp;
		pending_rsp.push_back(r);
		if (fn == FN_INIT)
			live_offsets.delete();
		if (fn == FN_ALLOC && r.st == ST_OK)
			live_offsets.push_back(r.gr);
		if (fn == FN_FREE) begin
			for (i = 0; i < live_offsets.size(); i++) begin
				if (live_offsets[i] == off) begin
					live_offsets.delete(i);
					break;
				end
			end
		end
	endtask

	task automatic pause_sender(int n);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic write_usable(int addr, int value);
		pause_sender(1);
		wait (pending_rsp.size() == 0);
		pause_sender(8);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr[2:0];
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == 0)
			usable_reg = value & 32'h1FFF;
	endtask

	task automatic random_request();
		rsp_t none;
		int pick, sz;
		none = '{ST_OK, '0, '0};
		pick = $urandom_range(99);
		if (pick < 46) begin
			sz = $urandom_range(99);
			if (sz < 70)
				sz = $urandom_range(64, 1);
			else if (sz < 93)
				sz = $urandom_range(512, 65);
			else if (sz < 97)
				sz = $urandom_range(8191, 0);
			else
				sz = 0;
			send_request(FN_ALLOC, sz, 0, 0, none);
		end else if (pick < 82) begin
			if (live_offsets.size() != 0 && $urandom_range(9) < 8)
				send_request(FN_FREE, 0,
					live_offsets[$urandom_range(live_offsets.size() - 1)], 0, none);
			else
				send_request(FN_FREE, 0, $urandom_range(4095), 0, none);
		end else if (pick < 97) begin
			send_request(FN_QUERY, $urandom_range(8191), $urandom_range(4095), 0, none);
		end else begin
			send_request(FN_INIT, $urandom_range(8191), $urandom_range(4095), 0, none);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("unexpected response transfer: status %0d", rsp_ch.status);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.status !== want.st || rsp_ch.granted_offset !== want.gr ||
					rsp_ch.largest_free !== want.lf) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected st %0d gr %0d lf %0d, got st %0d gr %0d lf %0d",
							want.st, want.gr, want.lf, rsp_ch.status,
							rsp_ch.granted_offset, rsp_ch.largest_free);
				end
			end
		end
	end

	initial begin
		int mode, hold_cnt, mode_cnt;
		rsp_ch.ready = 1'b0;
		mode = 0;
		hold_cnt = 0;
		mode_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 3000;
			end
			if (mode_cnt == 0) begin
				mode = $urandom_range(2);
				mode_cnt = $urandom_range(400, 50);
			end
			mode_cnt--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_ch.ready <= 1'b0;
			end else if (mode == 0) begin
				rsp_ch.ready <= 1'b1;
			end else if (mode == 1) begin
				rsp_ch.ready <= $urandom_range(1);
			end else begin
				rsp_ch.ready <= ($urandom_range(3) == 0);
			end
		end
	end

	initial begin
		int i, ph, n, burst;
		int sizes [6];
		rsp_t typed_rsp;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_INIT;
		req_ch.req_bytes = '0;
		req_ch.payload_offset = '0;
		errors = 0;
		mismatches = 0;
		hold_req = 0;
		list_end = 0;
		list_ready = 0;
		usable_reg = 4096;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		for (i = 0; i < 25; i++) begin
			typed_rsp = '{dir_rows[i].st, 12'(dir_rows[i].gr), 13'(dir_rows[i].lf)};
			send_request(dir_rows[i].fn, dir_rows[i].req, dir_rows[i].off,
				dir_rows[i].typed, typed_rsp);
		end

		sizes = '{8191, 16, 13, 1000, 4096, 0};
		for (ph = 0; ph < 6; ph++) begin
			write_usable(0, ph == 5 ? $urandom_range(8191) : sizes[ph]);
			if (ph == 2)
				write_usable(4, $urandom_range(8191));
			typed_rsp = '{ST_OK, '0, '0};
			send_request(FN_INIT, $urandom_range(8191), $urandom_range(4095), 0, typed_rsp);
			n = 0;
			while (n < 100) begin
				if (ph == 3 && n == 20)
					hold_req = 1;
				if (ph == 4 && n == 50) begin
					pause_sender(1);
					wait (pending_rsp.size() == 0);
					pause_sender(3);
				end
				burst = $urandom_range(12, 1);
				while (burst > 0 && n < 100) begin
					random_request();
					burst--;
					n++;
				end
				if ($urandom_range(3) != 0)
					pause_sender($urandom_range(30));
			end
		end
		pause_sender(1);
		wait (pending_rsp.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
